@@ src/grid_second_derivative_stencil_defines.svh @@
// Assertion helpers used by the stencil top module.
`ifndef GRID_SECOND_DERIVATIVE_STENCIL_DEFINES_SVH
`define GRID_SECOND_DERIVATIVE_STENCIL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GSDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/gsds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gsds_pkg;

    // Default sizes
    localparam int MAX_COLS_DEF    = 256;
    localparam int MAX_ROWS_DEF    = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_SQ      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DZ_SQ      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOUR_DX_DZ = 3'd4;

    // Configuration reset values
    localparam logic [8:0]  GRID_WIDTH_RST     = 9'd256;
    localparam logic [8:0]  GRID_DEPTH_RST     = 9'd256;
    localparam logic [31:0] INV_DX_SQ_RST      = 32'd65536;
    localparam logic [31:0] INV_DZ_SQ_RST      = 32'd65536;
    localparam logic [31:0] INV_FOUR_DX_DZ_RST = 32'd16384;

    // Input function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Microcode fields
    typedef enum logic [1:0] {OFF_ZERO, OFF_PLUS, OFF_MINUS} off_t;
    typedef enum logic [1:0] {COEF_NONE, COEF_PLUS1, COEF_MINUS1, COEF_MINUS2} coef_t;
    typedef enum logic [1:0] {MUL_NONE, MUL_XX, MUL_XZ, MUL_ZZ} mul_t;
    typedef enum logic {COND_NONE, COND_SKIP} cond_t;

    localparam int STEP_W = 4;

    typedef struct packed {
        logic              rd;       // issue a grid read
        off_t              col_off;  // column offset from the center
        off_t              row_off;  // row offset from the center
        coef_t             xx;       // weight of this sample in d2/dx2
        coef_t             xz;       // weight in d2/dxdz
        coef_t             zz;       // weight in d2/dz2
        mul_t              mul;      // sum to scale this step
        cond_t             cond;     // jump condition
        logic [STEP_W-1:0] target;   // jump target
        logic              done;     // hand the result to the output
        logic              zero;     // result is all zero
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        rd: 1'b0, col_off: OFF_ZERO, row_off: OFF_ZERO,
        xx: COEF_NONE, xz: COEF_NONE, zz: COEF_NONE,
        mul: MUL_NONE, cond: COND_NONE, target: '0, done: 1'b0, zero: 1'b0
    };

    localparam logic [STEP_W-1:0] STEP_ZERO = 4'd15;

    // Control program
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = CW_NOP;
        case (step)
            4'd0:
            begin
                w.cond   = COND_SKIP;
                w.target = STEP_ZERO;
            end
            4'd1:
            begin
                w.rd = 1'b1; w.xx = COEF_MINUS2; w.zz = COEF_MINUS2;
            end
            4'd2:
            begin
                w.rd = 1'b1; w.col_off = OFF_MINUS; w.xx = COEF_PLUS1;
            end
            4'd3:
            begin
                w.rd = 1'b1; w.col_off = OFF_PLUS; w.xx = COEF_PLUS1;
            end
            4'd4:
            begin
                w.rd = 1'b1; w.row_off = OFF_MINUS; w.zz = COEF_PLUS1;
            end
            4'd5:
            begin
                w.rd = 1'b1; w.row_off = OFF_PLUS; w.zz = COEF_PLUS1;
            end
            4'd6:
            begin
                w.rd = 1'b1; w.col_off = OFF_MINUS; w.row_off = OFF_MINUS;
                w.xz = COEF_PLUS1;
            end
            4'd7:
            begin
                w.rd = 1'b1; w.col_off = OFF_PLUS; w.row_off = OFF_PLUS;
                w.xz = COEF_PLUS1;
            end
            4'd8:
            begin
                w.rd = 1'b1; w.col_off = OFF_MINUS; w.row_off = OFF_PLUS;
                w.xz = COEF_MINUS1;
            end
            4'd9:
            begin
                w.rd = 1'b1; w.col_off = OFF_PLUS; w.row_off = OFF_MINUS;
                w.xz = COEF_MINUS1;
            end
            4'd10:   w.mul = MUL_XX;
            4'd11:   w.mul = MUL_XZ;
            4'd12:   w.mul = MUL_ZZ;
            4'd13:   w = CW_NOP;      // last product saturates here
            4'd14:   w.done = 1'b1;
            4'd15:
            begin
                w.done = 1'b1; w.zero = 1'b1;
            end
            default: w = CW_NOP;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ src/gsds_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Step counter over the control program.
module gsds_seq
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,   // item accepted
    input  wire                         skip,    // write or corner: no stencil
    input  wire                         hold,    // output slot still full
    output logic                        busy,
    output gsds_pkg::ctrl_word_t        ctrl
);

    logic                        busy_reg, busy_next;
    logic [gsds_pkg::STEP_W-1:0] step_reg, step_next;
    gsds_pkg::ctrl_word_t        word;

    assign word = gsds_pkg::ucode_rom(step_reg);
    assign busy = busy_reg;
    assign ctrl = busy_reg ? word : gsds_pkg::CW_NOP;

    // Next step
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (word.done)
            begin
                if (!hold)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (word.cond == gsds_pkg::COND_SKIP && skip)
            begin
                step_next = word.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

@@ src/grid_second_derivative_stencil.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "grid_second_derivative_stencil_defines.svh"

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: col, row, sample
// m_*       out  m_tvalid/m_tready  tdata: xx, xz, zz; tuser: saturated
// cfg_*     in   cfg_wr_en          cfg_addr: register, cfg_data: value
//
// A read runs nine grid reads through the single memory port, one per step, then
// three steps on the shared multiplier. A write or a corner read jumps from the
// first step to the zero result; the sample is written at the accept edge.
// Reset clears control, the sums and the configuration registers; the grid holds no reset value.
// A result waits in the output register; a new item is taken once the
// sequencer has handed its result over.
module grid_second_derivative_stencil
#(
    parameter int MAX_COLS    = gsds_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = gsds_pkg::MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = gsds_pkg::SAMPLE_BITS_DEF
)
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    // input beats
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [((16+SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,  // col_index, row_index, sample_value
    input  wire                                   s_tuser,  // func
    // result beats
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [95:0]                           m_tdata,  // deriv_xx, deriv_xz, deriv_zz
    output logic                                  m_tuser,  // saturated
    // configuration writes
    input  wire                                   cfg_wr_en,
    input  wire  [gsds_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire  [31:0]                           cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CSZ_W  = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
    localparam int RSZ_W  = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int ACC_W  = SAMPLE_BITS + 2;
    localparam int PROD_W = ACC_W + 33;

    localparam logic [CSZ_W-1:0] MAX_COLS_C = CSZ_W'(MAX_COLS);
    localparam logic [RSZ_W-1:0] MAX_ROWS_C = RSZ_W'(MAX_ROWS);
    localparam logic [CSZ_W-1:0] MIN_COLS_C = CSZ_W'(3);
    localparam logic [RSZ_W-1:0] MIN_ROWS_C = RSZ_W'(3);

    // Configuration registers
    logic [8:0]  grid_width_reg, grid_depth_reg;
    logic [31:0] inv_dx_sq_reg, inv_dz_sq_reg, inv_four_dx_dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg     <= gsds_pkg::GRID_WIDTH_RST;
            grid_depth_reg     <= gsds_pkg::GRID_DEPTH_RST;
            inv_dx_sq_reg      <= gsds_pkg::INV_DX_SQ_RST;
            inv_dz_sq_reg      <= gsds_pkg::INV_DZ_SQ_RST;
            inv_four_dx_dz_reg <= gsds_pkg::INV_FOUR_DX_DZ_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                gsds_pkg::CFG_GRID_WIDTH:     grid_width_reg     <= cfg_data[8:0];
                gsds_pkg::CFG_GRID_DEPTH:     grid_depth_reg     <= cfg_data[8:0];
                gsds_pkg::CFG_INV_DX_SQ:      inv_dx_sq_reg      <= cfg_data;
                gsds_pkg::CFG_INV_DZ_SQ:      inv_dz_sq_reg      <= cfg_data;
                gsds_pkg::CFG_INV_FOUR_DX_DZ: inv_four_dx_dz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input fields
    logic                   in_func;
    logic [7:0]             in_col, in_row;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic                   s_accept;

    assign in_func   = s_tuser;
    assign in_col    = s_tdata[7:0];
    assign in_row    = s_tdata[15:8];
    assign in_sample = s_tdata[16 +: SAMPLE_BITS];

    // Sequencer
    gsds_pkg::ctrl_word_t ctrl;
    logic                 seq_busy;
    logic                 skip_reg, skip_next;
    logic                 out_free;

    assign s_tready = !seq_busy;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    gsds_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s_accept),
        .skip  (skip_reg),
        .hold  (!out_free),
        .busy  (seq_busy),
        .ctrl  (ctrl)
    );

    // Point clamping at accept
    logic [CSZ_W-1:0] w_use, col_ext, col_c, cen_col_next, cen_col_reg;
    logic [RSZ_W-1:0] d_use, row_ext, row_c, cen_row_next, cen_row_reg;
    logic             col_edge, row_edge;

    always_comb
    begin
        if (CSZ_W'(grid_width_reg) < MIN_COLS_C)
            w_use = MIN_COLS_C;
        else if (CSZ_W'(grid_width_reg) > MAX_COLS_C)
            w_use = MAX_COLS_C;
        else
            w_use = CSZ_W'(grid_width_reg);
        if (RSZ_W'(grid_depth_reg) < MIN_ROWS_C)
            d_use = MIN_ROWS_C;
        else if (RSZ_W'(grid_depth_reg) > MAX_ROWS_C)
            d_use = MAX_ROWS_C;
        else
            d_use = RSZ_W'(grid_depth_reg);

        col_ext = CSZ_W'(in_col);
        row_ext = RSZ_W'(in_row);
        col_c   = (col_ext >= w_use) ? w_use - 1'b1 : col_ext;
        row_c   = (row_ext >= d_use) ? d_use - 1'b1 : row_ext;

        col_edge = (col_c == '0) || (col_c == w_use - 1'b1);
        row_edge = (row_c == '0) || (row_c == d_use - 1'b1);

        // edge points move to the nearest interior point
        if (col_c == '0)
            cen_col_next = CSZ_W'(1);
        else if (col_c == w_use - 1'b1)
            cen_col_next = w_use - CSZ_W'(2);
        else
            cen_col_next = col_c;
        if (row_c == '0)
            cen_row_next = RSZ_W'(1);
        else if (row_c == d_use - 1'b1)
            cen_row_next = d_use - RSZ_W'(2);
        else
            cen_row_next = row_c;

        skip_next = (in_func == gsds_pkg::FUNC_WRITE) || (col_edge && row_edge);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            skip_reg <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cen_col_reg <= cen_col_next;
            cen_row_reg <= cen_row_next;
        end
    end

    // Grid memory: written at accept, read by the program
    logic [SAMPLE_BITS-1:0] grid_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [CSZ_W-1:0]       rd_col;
    logic [RSZ_W-1:0]       rd_row;
    logic [ADDR_W-1:0]      rd_addr, wr_addr;
    logic                   mem_we;

    always_comb
    begin
        case (ctrl.col_off)
            gsds_pkg::OFF_PLUS:  rd_col = cen_col_reg + 1'b1;
            gsds_pkg::OFF_MINUS: rd_col = cen_col_reg - 1'b1;
            default:             rd_col = cen_col_reg;
        endcase
        case (ctrl.row_off)
            gsds_pkg::OFF_PLUS:  rd_row = cen_row_reg + 1'b1;
            gsds_pkg::OFF_MINUS: rd_row = cen_row_reg - 1'b1;
            default:             rd_row = cen_row_reg;
        endcase
    end

    assign rd_addr = {rd_row[ROW_W-1:0], rd_col[COL_W-1:0]};
    assign wr_addr = {row_ext[ROW_W-1:0], col_ext[COL_W-1:0]};
    assign mem_we  = s_accept && (in_func == gsds_pkg::FUNC_WRITE)
                     && (col_ext < MAX_COLS_C) && (row_ext < MAX_ROWS_C);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[wr_addr] <= in_sample;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    // Control word delayed to line up with the read data and the product
    gsds_pkg::ctrl_word_t ctrl_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_d_reg <= gsds_pkg::CW_NOP;
        else
            ctrl_d_reg <= ctrl;
    end

    // Difference sums
    logic signed [ACC_W-1:0] acc_xx_reg, acc_xz_reg, acc_zz_reg;
    logic signed [ACC_W-1:0] acc_xx_next, acc_xz_next, acc_zz_next;
    logic signed [ACC_W-1:0] samp_ext;

    assign samp_ext = ACC_W'($signed(rd_data_reg));

    function automatic logic signed [ACC_W-1:0] weigh(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ACC_W-1:0] s,
        input gsds_pkg::coef_t         coef
    );
        logic signed [ACC_W-1:0] r;
        case (coef)
            gsds_pkg::COEF_PLUS1:  r = acc + s;
            gsds_pkg::COEF_MINUS1: r = acc - s;
            gsds_pkg::COEF_MINUS2: r = acc - (s <<< 1);
            default:               r = acc;
        endcase
        return r;
    endfunction

    always_comb
    begin
        acc_xx_next = weigh(acc_xx_reg, samp_ext, ctrl_d_reg.xx);
        acc_xz_next = weigh(acc_xz_reg, samp_ext, ctrl_d_reg.xz);
        acc_zz_next = weigh(acc_zz_reg, samp_ext, ctrl_d_reg.zz);
    end

    // Shared multiplier, one sum per step
    logic signed [ACC_W-1:0]  mul_a;
    logic        [31:0]       mul_k;
    logic signed [PROD_W-1:0] mul_a_ext, mul_k_ext, prod_reg;

    always_comb
    begin
        case (ctrl.mul)
            gsds_pkg::MUL_XZ:
            begin
                mul_a = acc_xz_reg; mul_k = inv_four_dx_dz_reg;
            end
            gsds_pkg::MUL_ZZ:
            begin
                mul_a = acc_zz_reg; mul_k = inv_dz_sq_reg;
            end
            default:
            begin
                mul_a = acc_xx_reg; mul_k = inv_dx_sq_reg;
            end
        endcase
        mul_a_ext = PROD_W'(mul_a);
        mul_k_ext = $signed(PROD_W'(mul_k));
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a_ext * mul_k_ext;
    end

    // Saturation to 32 bits
    logic        prod_ovf;
    logic [31:0] prod_sat;

    always_comb
    begin
        prod_ovf = (|prod_reg[PROD_W-1:31]) && !(&prod_reg[PROD_W-1:31]);
        if (prod_ovf)
            prod_sat = prod_reg[PROD_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            prod_sat = prod_reg[31:0];
    end

    logic [31:0] res_xx_reg, res_xz_reg, res_zz_reg;
    logic        clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_xx_reg <= '0;
            acc_xz_reg <= '0;
            acc_zz_reg <= '0;
            clip_reg   <= 1'b0;
        end
        else if (s_accept)
        begin
            acc_xx_reg <= '0;
            acc_xz_reg <= '0;
            acc_zz_reg <= '0;
            clip_reg   <= 1'b0;
        end
        else
        begin
            acc_xx_reg <= acc_xx_next;
            acc_xz_reg <= acc_xz_next;
            acc_zz_reg <= acc_zz_next;
            if (ctrl_d_reg.mul != gsds_pkg::MUL_NONE && prod_ovf)
                clip_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl_d_reg.mul)
            gsds_pkg::MUL_XX: res_xx_reg <= prod_sat;
            gsds_pkg::MUL_XZ: res_xz_reg <= prod_sat;
            gsds_pkg::MUL_ZZ: res_zz_reg <= prod_sat;
            default: ;
        endcase
    end

    // Output register
    logic        out_fire;
    logic        m_tvalid_reg;
    logic [95:0] out_data_reg;
    logic        out_sat_reg;

    assign out_fire = ctrl.done && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_fire)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            if (ctrl.zero)
            begin
                out_data_reg <= '0;
                out_sat_reg  <= 1'b0;
            end
            else
            begin
                out_data_reg <= {res_zz_reg, res_xz_reg, res_xx_reg};
                out_sat_reg  <= clip_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

    // Checks
    `GSDS_ASSERT_NEXT(a_accept_starts, s_accept, seq_busy,
        "accepted item did not start the sequencer")
    `GSDS_ASSERT_NOW(a_no_write_busy, mem_we, !seq_busy,
        "grid written while the program runs")
    `GSDS_ASSERT_NOW(a_sat_bound, m_tvalid && m_tuser,
        m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000 ||
        m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000 ||
        m_tdata[95:64] == 32'h7fff_ffff || m_tdata[95:64] == 32'h8000_0000,
        "saturated flag without a clipped field")

endmodule

`default_nettype wire

@@ tb/sv/stencil_checker.sv @@
`timescale 1ns / 1ps

module stencil_checker
    import gsds_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    input  wire                  s_tready,
    input  wire  [31:0]          s_tdata,   // col_index, row_index, sample_value
    input  wire                  s_tuser,   // func
    input  wire                  m_tvalid,
    input  wire                  m_tready,
    input  wire  [95:0]          m_tdata,   // deriv_xx, deriv_xz, deriv_zz
    input  wire                  m_tuser,   // saturated
    input  wire                  cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0] cfg_addr,
    input  wire  [31:0]          cfg_data,
    output int                   fail_count,
    output int                   derivs_pending
);

    typedef struct packed {
        logic [31:0] xx;
        logic [31:0] xz;
        logic [31:0] zz;
        logic        sat;
    } deriv_set_t;

    // shadow of the sample grid and of the registers
    logic signed [15:0] grid_copy [0:MAX_COLS_DEF*MAX_ROWS_DEF-1];
    logic [8:0]         width_reg;
    logic [8:0]         depth_reg;
    logic [31:0]        k_xx;
    logic [31:0]        k_zz;
    logic [31:0]        k_xz;

    // derivatives still owed by the block, oldest first
    deriv_set_t         derivs_due [$];
    deriv_set_t         want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, wanted, $time);
        fail_count++;
    endtask

    function automatic longint sample_at(input int c, input int z);
        return longint'(grid_copy[z * MAX_COLS_DEF + c]);
    endfunction

    // difference times unsigned Q16.16 factor; bit 32 flags a clip
    function automatic logic [32:0] scale_clip(input longint diff, input logic [31:0] k);
        longint prod;
        prod = diff * longint'({32'd0, k});
        if (prod > 64'sd2147483647)
            return {1'b1, 32'h7FFF_FFFF};
        if (prod < -64'sd2147483648)
            return {1'b1, 32'h8000_0000};
        return {1'b0, prod[31:0]};
    endfunction

    function automatic deriv_set_t predict_derivs(input logic [7:0] col_in,
                                                  input logic [7:0] row_in);
        deriv_set_t r;
        int         w;
        int         d;
        int         c;
        int         z;
        longint     mid;
        longint     dxx;
        longint     dxz;
        longint     dzz;
        logic [32:0] t;
        r = '0;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(width_reg);
        d = (depth_reg < 3) ? 3 : (depth_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(depth_reg);
        c = (int'(col_in) >= w) ? w - 1 : int'(col_in);
        z = (int'(row_in) >= d) ? d - 1 : int'(row_in);
        // corners give all zero
        if ((c == 0 || c == w - 1) && (z == 0 || z == d - 1))
            return r;
        // edges borrow the nearest interior point
        if (c == 0) c = 1;
        if (c == w - 1) c = w - 2;
        if (z == 0) z = 1;
        if (z == d - 1) z = d - 2;
        mid = sample_at(c, z);
        dxx = sample_at(c + 1, z) - 2 * mid + sample_at(c - 1, z);
        dzz = sample_at(c, z + 1) - 2 * mid + sample_at(c, z - 1);
        dxz = sample_at(c + 1, z + 1) - sample_at(c + 1, z - 1)
            - sample_at(c - 1, z + 1) + sample_at(c - 1, z - 1);
        t = scale_clip(dxx, k_xx);
        r.xx = t[31:0];
        r.sat = t[32];
        t = scale_clip(dxz, k_xz);
        r.xz = t[31:0];
        r.sat = r.sat | t[32];
        t = scale_clip(dzz, k_zz);
        r.zz = t[31:0];
        r.sat = r.sat | t[32];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = GRID_WIDTH_RST;
            depth_reg  = GRID_DEPTH_RST;
            k_xx       = INV_DX_SQ_RST;
            k_zz       = INV_DZ_SQ_RST;
            k_xz       = INV_FOUR_DX_DZ_RST;
            fail_count = 0;
            derivs_due.delete();
        end
        else
        begin
            // register writes
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_GRID_WIDTH:     width_reg = cfg_data[8:0];
                    CFG_GRID_DEPTH:     depth_reg = cfg_data[8:0];
                    CFG_INV_DX_SQ:      k_xx = cfg_data;
                    CFG_INV_DZ_SQ:      k_zz = cfg_data;
                    CFG_INV_FOUR_DX_DZ: k_xz = cfg_data;
                    default:            ;
                endcase
            end
            // result beat against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (derivs_due.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata[31:0], '0);
                else
                begin
                    want = derivs_due.pop_front();
                    if (m_tdata[31:0] !== want.xx)
                        report_mismatch("deriv_xx", m_tdata[31:0], want.xx);
                    if (m_tdata[63:32] !== want.xz)
                        report_mismatch("deriv_xz", m_tdata[63:32], want.xz);
                    if (m_tdata[95:64] !== want.zz)
                        report_mismatch("deriv_zz", m_tdata[95:64], want.zz);
                    if (m_tuser !== want.sat)
                        report_mismatch("saturated", {31'd0, m_tuser}, {31'd0, want.sat});
                end
            end
            // input beat: store a sample or predict a read
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == FUNC_WRITE)
                begin
                    grid_copy[s_tdata[15:0]] = s_tdata[31:16];
                    derivs_due.push_back('0);
                end
                else
                    derivs_due.push_back(predict_derivs(s_tdata[7:0], s_tdata[15:8]));
            end
        end
        derivs_pending = derivs_due.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import gsds_pkg::*;

    localparam int ITEM_TARGET  = 1300;
    localparam int PHASES       = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 150;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // col_index, row_index, sample_value
    logic                 s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [95:0]          m_tdata;   // deriv_xx, deriv_xz, deriv_zz
    logic                 m_tuser;   // saturated
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [31:0]          cfg_data;

    int fail_count;
    int derivs_pending;
    int items_sent   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;
    int eff_w;
    int eff_d;

    // grid entries that hold a written sample
    bit written_map [0:MAX_COLS_DEF*MAX_ROWS_DEF-1];

    grid_second_derivative_stencil u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    stencil_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .derivs_pending (derivs_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: cycles without any beat or register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_k();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // mostly near a hot spot, sometimes on the edges or anywhere
    function automatic logic [7:0] pick_index(input int hot);
        int v;
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return 8'($urandom_range(0, 255));
            default:
            begin
                v = hot + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return 8'(v);
            end
        endcase
    endfunction

    // one input beat; returns at the edge where it was accepted
    task automatic send_beat(input logic fn, input logic [7:0] col, input logic [7:0] row,
                             input logic [15:0] smp);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {smp, row, col};
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        items_sent++;
        if (fn == FUNC_WRITE)
            written_map[{row, col}] = 1'b1;
    endtask

    // read, after filling any unwritten entry of its stencil
    task automatic read_point(input logic [7:0] col, input logic [7:0] row);
        int c;
        int z;
        int dx;
        int dz;
        c = (int'(col) >= eff_w) ? eff_w - 1 : int'(col);
        z = (int'(row) >= eff_d) ? eff_d - 1 : int'(row);
        if (!((c == 0 || c == eff_w - 1) && (z == 0 || z == eff_d - 1)))
        begin
            if (c == 0) c = 1;
            if (c == eff_w - 1) c = eff_w - 2;
            if (z == 0) z = 1;
            if (z == eff_d - 1) z = eff_d - 2;
            for (dz = -1; dz <= 1; dz++)
                for (dx = -1; dx <= 1; dx++)
                    if (!written_map[(z + dz) * MAX_COLS_DEF + c + dx])
                        send_beat(FUNC_WRITE, 8'(c + dx), 8'(z + dz), rand_sample());
        end
        send_beat(FUNC_READ, col, row, 16'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [8:0] w, input logic [8:0] d, input logic [31:0] kx,
                            input logic [31:0] kz, input logic [31:0] kxz);
        write_reg(CFG_GRID_WIDTH, {23'($urandom), w});
        write_reg(CFG_GRID_DEPTH, {23'($urandom), d});
        write_reg(CFG_INV_DX_SQ, kx);
        write_reg(CFG_INV_DZ_SQ, kz);
        write_reg(CFG_INV_FOUR_DX_DZ, kxz);
        cfg_wr_en <= 1'b0;
        eff_w = (w < 3) ? 3 : (w > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(w);
        eff_d = (d < 3) ? 3 : (d > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(d);
    endtask

    // let every owed result come out, then settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (derivs_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_items(input int stop_at);
        int          hot_c;
        int          hot_r;
        logic [7:0]  col;
        logic [7:0]  row;
        hot_c = $urandom_range(0, 255);
        hot_r = $urandom_range(0, 255);
        while (items_sent < stop_at)
        begin
            col = pick_index(hot_c);
            row = pick_index(hot_r);
            if ($urandom_range(0, 99) < 35)
                send_beat(FUNC_WRITE, col, row, rand_sample());
            else
                read_point(col, row);
        end
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial
    begin
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int phase;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_WRITE;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_GRID_WIDTH;
        cfg_data  <= '0;
        eff_w = MAX_COLS_DEF;
        eff_d = MAX_ROWS_DEF;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: full-scale stencil around (1,1)
        send_beat(FUNC_WRITE, 8'd1, 8'd1, 16'h8000);
        send_beat(FUNC_WRITE, 8'd0, 8'd1, 16'h7FFF);
        send_beat(FUNC_WRITE, 8'd2, 8'd1, 16'h7FFF);
        send_beat(FUNC_WRITE, 8'd1, 8'd0, 16'h8000);
        send_beat(FUNC_WRITE, 8'd1, 8'd2, 16'h8000);
        send_beat(FUNC_WRITE, 8'd0, 8'd0, 16'h7FFF);
        send_beat(FUNC_WRITE, 8'd2, 8'd2, 16'h7FFF);
        send_beat(FUNC_WRITE, 8'd0, 8'd2, 16'h8000);
        send_beat(FUNC_WRITE, 8'd2, 8'd0, 16'h8000);
        // write past nothing in use, still kept
        send_beat(FUNC_WRITE, 8'd255, 8'd255, 16'h5AA5);
        read_point(8'd1, 8'd1);
        // edges take the interior neighbor
        read_point(8'd0, 8'd1);
        read_point(8'd1, 8'd0);
        // corners
        read_point(8'd0, 8'd0);
        read_point(8'd255, 8'd255);
        read_point(8'd0, 8'd255);
        read_point(8'd255, 8'd0);
        drain();

        // smallest grid: indexes beyond it clamp to the last column and row
        set_grid(9'd3, 9'd3, INV_DX_SQ_RST, INV_DZ_SQ_RST, INV_FOUR_DX_DZ_RST);
        read_point(8'd255, 8'd1);
        read_point(8'd1, 8'd255);
        read_point(8'd2, 8'd2);
        // negative clip along x
        send_beat(FUNC_WRITE, 8'd1, 8'd1, 16'h7FFF);
        send_beat(FUNC_WRITE, 8'd0, 8'd1, 16'h8000);
        send_beat(FUNC_WRITE, 8'd2, 8'd1, 16'h8000);
        read_point(8'd1, 8'd1);
        drain();

        // random phases, each under its own settings
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:  set_grid(9'd0, 9'd511, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
                1:  set_grid(9'd511, 9'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
                2:  set_grid(9'd256, 9'd256, rand_k(), rand_k(), rand_k());
                3:  set_grid(9'd4, 9'd3, rand_k(), rand_k(), rand_k());
                4:  set_grid(9'd257, 9'd3, rand_k(), rand_k(), rand_k());
                PHASES - 1:
                    set_grid(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                             rand_k(), rand_k(), rand_k());
                default:
                    set_grid(9'($urandom_range(0, 24)), 9'($urandom_range(0, 24)),
                             rand_k(), rand_k(), rand_k());
            endcase
            calm = (phase == PHASES - 1);
            random_items(items_sent + (ITEM_TARGET - items_sent) / (PHASES - phase));
            drain();
        end

        @(negedge clk);
        if (fail_count == 0 && derivs_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
